FILE: rtl/core/wpd_pkg.sv
// shared constants and types of the window peak detector
package wpd_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int COORD_BITS        = 9;
    localparam int PEAK_INDEX_BITS   = 18;
    localparam int FRAME_DIM_BITS    = 10;
    localparam int THRESHOLD_BITS    = 16;
    localparam int HALF_WINDOW_BITS  = 3;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 16;
    localparam int FRAME_DIM_RESET   = 512;
    localparam int HALF_WINDOW_RESET = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_PEAK_THRESH  = 2'd2,
        REG_HALF_WINDOW  = 2'd3
    } cfg_reg_t;

    // per-sample control that travels alongside the window data
    typedef struct packed {
        logic                  qualify;
        logic                  frame_last;
        logic [COORD_BITS-1:0] ccol;
        logic [COORD_BITS-1:0] crow;
    } meta_t;

endpackage

FILE: rtl/core/wpd_sample_if.sv
// input channel of the window peak detector: one grid sample per beat
interface wpd_sample_if import wpd_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);

endinterface

FILE: rtl/core/wpd_peak_if.sv
// output channel of the window peak detector: one peak per beat
interface wpd_peak_if import wpd_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [COORD_BITS-1:0]      peak_col;
    logic [COORD_BITS-1:0]      peak_row;
    logic [PEAK_INDEX_BITS-1:0] peak_index;

    modport source (output valid, output peak_col, output peak_row, output peak_index,
                    input ready);
    modport sink (input valid, input peak_col, input peak_row, input peak_index,
                  output ready);

endinterface

FILE: rtl/core/wpd_line_buffer.sv
// cascaded line memories that deliver one vertical column of samples per beat
module wpd_line_buffer #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_HALF_WINDOW = 4,
    parameter int VALUE_BITS      = 16,
    localparam int COL_BITS       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int TAPS           = 2 * MAX_HALF_WINDOW + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [COL_BITS-1:0]            rd_col,
    input  logic [VALUE_BITS-1:0]          sample,
    input  logic                           wr_en,
    output logic [TAPS-1:0][VALUE_BITS-1:0] taps
);

    logic [VALUE_BITS-1:0] sample_reg;
    logic [COL_BITS-1:0]   col_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            sample_reg <= sample;
            col_reg    <= rd_col;
        end
    end

    assign taps[0] = sample_reg;

    generate
        if (MAX_HALF_WINDOW > 0)
        begin : g_lines
            localparam int LINES = TAPS - 1;

            logic                             fwd_reg;
            logic [LINES-1:0][VALUE_BITS-1:0] fwd_data_reg;

            // a read of the column being written in the same cycle takes the new data
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    fwd_reg <= 1'b0;
                end
                else if (rd_en)
                begin
                    fwd_reg <= wr_en && (rd_col == col_reg);
                end
            end

            always_ff @(posedge clk)
            begin
                if (rd_en)
                begin
                    fwd_data_reg <= taps[LINES-1:0];
                end
            end

            for (genvar k = 0; k < LINES; k++)
            begin : g_line
                logic [VALUE_BITS-1:0] mem [0:MAX_WIDTH-1];
                logic [VALUE_BITS-1:0] q_reg;

                // line k holds the row k+1 above the current one
                always_ff @(posedge clk)
                begin
                    if (rd_en)
                    begin
                        q_reg <= mem[rd_col];
                    end
                    if (wr_en)
                    begin
                        mem[col_reg] <= taps[k];
                    end
                end

                assign taps[k+1] = fwd_reg ? fwd_data_reg[k] : q_reg;
            end
        end
    endgenerate

endmodule

FILE: rtl/core/wpd_max_tree.sv
// pipelined maximum over one column of the window, one register per tree level
module wpd_max_tree import wpd_pkg::*; #(
    parameter int VALUE_BITS = 16,
    parameter int LEAVES     = 9,
    localparam int LEVELS    = (LEAVES > 1) ? $clog2(LEAVES) : 0,
    localparam int NP        = 1 << LEVELS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  meta_t                            in_meta,
    input  logic [VALUE_BITS-1:0]            in_center,
    input  logic [LEAVES-1:0][VALUE_BITS-1:0] in_leaf,
    output logic                             out_valid,
    output meta_t                            out_meta,
    output logic [VALUE_BITS-1:0]            out_center,
    output logic [VALUE_BITS-1:0]            out_max
);

    generate
        if (LEVELS == 0)
        begin : g_single
            assign out_valid  = in_valid;
            assign out_meta   = in_meta;
            assign out_center = in_center;
            assign out_max    = in_leaf[0];
        end
        else
        begin : g_tree
            logic [NP-1:0][VALUE_BITS-1:0] leaf;
            logic [VALUE_BITS-1:0]         node_reg [1:LEVELS][0:NP/2-1];
            logic [LEVELS:1]               valid_reg;
            meta_t                         meta_reg [1:LEVELS];
            logic [VALUE_BITS-1:0]         center_reg [1:LEVELS];

            // missing leaves are zero, which never wins against a sample
            always_comb
            begin
                leaf = '0;
                for (int i = 0; i < LEAVES; i++)
                begin
                    leaf[i] = in_leaf[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= '0;
                end
                else if (en)
                begin
                    for (int l = LEVELS; l > 1; l--)
                    begin
                        valid_reg[l] <= valid_reg[l-1];
                    end
                    valid_reg[1] <= in_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int i = 0; i < NP / 2; i++)
                    begin
                        node_reg[1][i] <= (leaf[2*i] > leaf[2*i+1]) ? leaf[2*i] : leaf[2*i+1];
                    end
                    for (int l = 2; l <= LEVELS; l++)
                    begin
                        for (int i = 0; i < (NP >> l); i++)
                        begin
                            node_reg[l][i] <= (node_reg[l-1][2*i] > node_reg[l-1][2*i+1]) ?
                                              node_reg[l-1][2*i] : node_reg[l-1][2*i+1];
                        end
                    end
                    meta_reg[1]   <= in_meta;
                    center_reg[1] <= in_center;
                    for (int l = 2; l <= LEVELS; l++)
                    begin
                        meta_reg[l]   <= meta_reg[l-1];
                        center_reg[l] <= center_reg[l-1];
                    end
                end
            end

            assign out_valid  = valid_reg[LEVELS];
            assign out_meta   = meta_reg[LEVELS];
            assign out_center = center_reg[LEVELS];
            assign out_max    = node_reg[LEVELS][0];
        end
    endgenerate

endmodule

FILE: rtl/core/wpd_window_cell.sv
// one column cell of the horizontal chain: running maximum and center delay
module wpd_window_cell #(
    parameter int VALUE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [VALUE_BITS-1:0] col_max,
    input  logic [VALUE_BITS-1:0] max_in,
    input  logic [VALUE_BITS-1:0] ctr_in,
    output logic [VALUE_BITS-1:0] max_out,
    output logic [VALUE_BITS-1:0] ctr_out
);

    logic [VALUE_BITS-1:0] max_reg;
    logic [VALUE_BITS-1:0] max_next;
    logic [VALUE_BITS-1:0] ctr_reg;

    // the new column maximum joins the partial handed over by the left neighbor
    assign max_next = (max_in > col_max) ? max_in : col_max;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg <= max_next;
            ctr_reg <= ctr_in;
        end
    end

    assign max_out = max_reg;
    assign ctr_out = ctr_reg;

endmodule

FILE: rtl/core/window_peak_detector.sv
// window peak detector: 2d non-maximum suppression over a square window
//
// Samples enter on the sample channel in raster order, one per beat, with
// valid/ready. A center whose (2w+1)x(2w+1) window fits in the frame, whose
// value reaches the threshold and is not exceeded anywhere in its window is
// sent as one beat on the peak channel: column, row and peak index in frame.
// The decision for a center is taken with the last sample of its window.
// Throughput is one sample per cycle while sample ready is high; each line
// memory does one read and one write per cycle. A peak beat passes the
// line registers, max tree levels, window cells and output register.
// Geometry is set through the write port; writing width, height or half
// window starts a new frame. Reset restores the default geometry and counters
// and needs no clearing pass; the line memories are not cleared.
// The output register holds a peak while the receiver stalls; samples keep
// flowing until a second peak waits behind it, then sample ready drops.
module window_peak_detector import wpd_pkg::*; #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_HEIGHT      = 512,
    parameter int MAX_HALF_WINDOW = 4,
    parameter int VALUE_BITS      = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    wpd_sample_if.sink                sample,
    wpd_peak_if.source                peak,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HW_BITS   = (MAX_HALF_WINDOW > 0) ? $clog2(MAX_HALF_WINDOW + 1) : 1;
    localparam int TAPS      = 2 * MAX_HALF_WINDOW + 1;
    localparam int SPAN_BITS = (TAPS > 1) ? $clog2(TAPS) : 1;

    localparam logic [COL_BITS-1:0] LAST_COL_RESET =
        COL_BITS'(((MAX_WIDTH < FRAME_DIM_RESET) ? MAX_WIDTH : FRAME_DIM_RESET) - 1);
    localparam logic [ROW_BITS-1:0] LAST_ROW_RESET =
        ROW_BITS'(((MAX_HEIGHT < FRAME_DIM_RESET) ? MAX_HEIGHT : FRAME_DIM_RESET) - 1);
    localparam logic [HW_BITS-1:0] HW_RESET =
        HW_BITS'((MAX_HALF_WINDOW < HALF_WINDOW_RESET) ? MAX_HALF_WINDOW : HALF_WINDOW_RESET);

    // configuration
    logic [COL_BITS-1:0]        last_col_reg;
    logic [ROW_BITS-1:0]        last_row_reg;
    logic [VALUE_BITS-1:0]      thr_reg;
    logic [HW_BITS-1:0]         hw_reg;
    logic [FRAME_DIM_BITS-1:0]  cfg_dim;
    logic [HALF_WINDOW_BITS-1:0] cfg_hw;
    logic [COL_BITS-1:0]        width_last;
    logic [ROW_BITS-1:0]        height_last;
    logic [HW_BITS-1:0]         hw_write;
    logic                       geom_write;

    // position counters
    logic [COL_BITS-1:0]        col_reg;
    logic [COL_BITS-1:0]        col_next;
    logic [ROW_BITS-1:0]        row_reg;
    logic [ROW_BITS-1:0]        row_next;
    logic                       col_at_last;
    logic                       row_at_last;
    logic [HW_BITS:0]           span0;

    // pipeline
    logic                       adv;
    logic                       accept;
    meta_t                      meta0;
    logic                       s1_valid_reg;
    meta_t                      s1_meta_reg;
    logic [TAPS-1:0][VALUE_BITS-1:0] taps;
    logic [TAPS-1:0][VALUE_BITS-1:0] leaves;
    logic [SPAN_BITS-1:0]       tap_sel;
    logic [SPAN_BITS-1:0]       span_sel;
    logic                       tree_valid;
    meta_t                      tree_meta;
    logic [VALUE_BITS-1:0]      tree_center;
    logic [VALUE_BITS-1:0]      tree_max;
    logic                       cell_en;
    logic [VALUE_BITS-1:0]      cell_max [0:TAPS-1];
    logic [VALUE_BITS-1:0]      cell_ctr [0:TAPS-1];
    logic                       h_valid_reg;
    meta_t                      h_meta_reg;
    logic [VALUE_BITS-1:0]      win_max;
    logic [VALUE_BITS-1:0]      win_center;
    logic                       h_peak;

    // output
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [COORD_BITS-1:0]      out_col_reg;
    logic [COORD_BITS-1:0]      out_row_reg;
    logic [PEAK_INDEX_BITS-1:0] out_index_reg;
    logic [PEAK_INDEX_BITS-1:0] peak_cnt_reg;
    logic [PEAK_INDEX_BITS-1:0] peak_cnt_next;

    // ---------------------------------------------------------------- config

    assign cfg_dim = cfg_wdata[FRAME_DIM_BITS-1:0];
    assign cfg_hw  = cfg_wdata[HALF_WINDOW_BITS-1:0];

    always_comb
    begin
        if (cfg_dim == '0)
        begin
            width_last  = '0;
            height_last = '0;
        end
        else
        begin
            if (int'(cfg_dim) > MAX_WIDTH)
            begin
                width_last = COL_BITS'(MAX_WIDTH - 1);
            end
            else
            begin
                width_last = COL_BITS'(int'(cfg_dim) - 1);
            end
            if (int'(cfg_dim) > MAX_HEIGHT)
            begin
                height_last = ROW_BITS'(MAX_HEIGHT - 1);
            end
            else
            begin
                height_last = ROW_BITS'(int'(cfg_dim) - 1);
            end
        end
        if (int'(cfg_hw) > MAX_HALF_WINDOW)
        begin
            hw_write = HW_BITS'(MAX_HALF_WINDOW);
        end
        else
        begin
            hw_write = HW_BITS'(cfg_hw);
        end
    end

    assign geom_write = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                   (cfg_index == REG_FRAME_HEIGHT) ||
                                   (cfg_index == REG_HALF_WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= LAST_COL_RESET;
            last_row_reg <= LAST_ROW_RESET;
            thr_reg      <= '0;
            hw_reg       <= HW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  last_col_reg <= width_last;
                REG_FRAME_HEIGHT: last_row_reg <= height_last;
                REG_PEAK_THRESH:  thr_reg      <= VALUE_BITS'(cfg_wdata[THRESHOLD_BITS-1:0]);
                REG_HALF_WINDOW:  hw_reg       <= hw_write;
                default:          ;
            endcase
        end
    end

    // --------------------------------------------------------- position

    assign accept       = sample.valid && sample.ready;
    assign col_at_last  = (col_reg == last_col_reg);
    assign row_at_last  = (row_reg == last_row_reg);
    assign span0        = {hw_reg, 1'b0};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (geom_write)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_at_last)
            begin
                col_next = '0;
                row_next = row_at_last ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        meta0.qualify    = (32'(col_reg) >= 32'(span0)) && (32'(row_reg) >= 32'(span0));
        meta0.frame_last = col_at_last && row_at_last;
        meta0.ccol       = COORD_BITS'(col_reg - COL_BITS'(hw_reg));
        meta0.crow       = COORD_BITS'(row_reg - ROW_BITS'(hw_reg));
    end

    // ----------------------------------------------------------- pipeline

    // everything moves unless a second peak would land on a stalled output
    assign adv          = !out_valid_reg || peak.ready || !h_peak;
    assign sample.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            h_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            h_valid_reg  <= tree_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_meta_reg <= meta0;
        end
        if (adv && tree_valid)
        begin
            h_meta_reg <= tree_meta;
        end
    end

    wpd_line_buffer #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .VALUE_BITS      (VALUE_BITS)
    ) u_line_buffer (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .rd_col (col_reg),
        .sample (VALUE_BITS'(sample.sample_value)),
        .wr_en  (adv && s1_valid_reg),
        .taps   (taps)
    );

    assign tap_sel  = SPAN_BITS'(hw_reg);
    assign span_sel = SPAN_BITS'(span0);

    // rows above the window are masked out of the column maximum
    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            leaves[k] = (SPAN_BITS'(k) <= span_sel) ? taps[k] : '0;
        end
    end

    wpd_max_tree #(
        .VALUE_BITS (VALUE_BITS),
        .LEAVES     (TAPS)
    ) u_max_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s1_valid_reg),
        .in_meta    (s1_meta_reg),
        .in_center  (taps[tap_sel]),
        .in_leaf    (leaves),
        .out_valid  (tree_valid),
        .out_meta   (tree_meta),
        .out_center (tree_center),
        .out_max    (tree_max)
    );

    assign cell_en = adv && tree_valid;

    // cell k holds the maximum over the last k+1 columns and the center row k columns back
    generate
        for (genvar k = 0; k < TAPS; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                wpd_window_cell #(
                    .VALUE_BITS (VALUE_BITS)
                ) u_cell (
                    .clk     (clk),
                    .en      (cell_en),
                    .col_max (tree_max),
                    .max_in  (tree_max),
                    .ctr_in  (tree_center),
                    .max_out (cell_max[k]),
                    .ctr_out (cell_ctr[k])
                );
            end
            else
            begin : g_body
                wpd_window_cell #(
                    .VALUE_BITS (VALUE_BITS)
                ) u_cell (
                    .clk     (clk),
                    .en      (cell_en),
                    .col_max (tree_max),
                    .max_in  (cell_max[k-1]),
                    .ctr_in  (cell_ctr[k-1]),
                    .max_out (cell_max[k]),
                    .ctr_out (cell_ctr[k])
                );
            end
        end
    endgenerate

    assign win_max    = cell_max[span_sel];
    assign win_center = cell_ctr[tap_sel];
    assign h_peak     = h_valid_reg && h_meta_reg.qualify &&
                        (win_center >= thr_reg) && (win_center >= win_max);

    // ------------------------------------------------------------- output

    always_comb
    begin
        peak_cnt_next = peak_cnt_reg;
        if (geom_write)
        begin
            peak_cnt_next = '0;
        end
        else if (adv && h_valid_reg)
        begin
            if (h_meta_reg.frame_last)
            begin
                peak_cnt_next = '0;
            end
            else
            begin
                peak_cnt_next = peak_cnt_reg + PEAK_INDEX_BITS'(h_peak);
            end
        end

        out_valid_next = out_valid_reg;
        if (adv && h_peak)
        begin
            out_valid_next = 1'b1;
        end
        else if (peak.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            peak_cnt_reg  <= peak_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && h_peak)
        begin
            out_col_reg   <= h_meta_reg.ccol;
            out_row_reg   <= h_meta_reg.crow;
            out_index_reg <= peak_cnt_reg;
        end
    end

    assign peak.valid      = out_valid_reg;
    assign peak.peak_col   = out_col_reg;
    assign peak.peak_row   = out_row_reg;
    assign peak.peak_index = out_index_reg;

`ifndef ASSERT_OFF
    a_peak_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !peak.ready && h_peak && !cfg_we |=> h_peak)
        else $error("pending peak lost while output stalled");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        adv && h_valid_reg && h_meta_reg.frame_last |=> peak_cnt_reg == '0)
        else $error("peak index not cleared at frame end");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= last_col_reg) && (row_reg <= last_row_reg))
        else $error("position counter beyond frame");
`endif

endmodule
